@@ sv/pdf_pkg.sv @@
// ----------------------------------------------------------------------------
// pdf_pkg: shared types and constants of the pipelined decode stage
// Instruction codes, register IDs, stream field layout and the register
// decode function used by the decode stage and its register file.
// ----------------------------------------------------------------------------
package pdf_pkg;

    localparam logic [3:0] IRRMOVQ = 4'd2;
    localparam logic [3:0] IIRMOVQ = 4'd3;
    localparam logic [3:0] IRMMOVQ = 4'd4;
    localparam logic [3:0] IMRMOVQ = 4'd5;
    localparam logic [3:0] IOPQ    = 4'd6;
    localparam logic [3:0] IJXX    = 4'd7;
    localparam logic [3:0] ICALL   = 4'd8;
    localparam logic [3:0] IRET    = 4'd9;
    localparam logic [3:0] IPUSHQ  = 4'd10;
    localparam logic [3:0] IPOPQ   = 4'd11;

    localparam logic [3:0] RSP   = 4'd4;
    localparam logic [3:0] RNONE = 4'd15;

    localparam int NUM_FWD = 5;

    // Input item layout, lowest bit first.
    localparam int IN_ICODE_LSB   = 0;
    localparam int IN_REG_A_LSB   = 4;
    localparam int IN_REG_B_LSB   = 8;
    localparam int IN_NEXT_PC_LSB = 12;
    localparam int IN_FWD_LSB     = 76;
    localparam int IN_VALS_LSB    = 100;
    localparam int IN_EICODE_LSB  = 420;
    localparam int IN_CND_LSB     = 424;
    localparam int IN_BITS        = 425;
    localparam int S_TDATA_W      = ((IN_BITS + 7) / 8) * 8;

    // Result item layout, lowest bit first.
    localparam int OUT_BITS  = 145;
    localparam int M_TDATA_W = ((OUT_BITS + 7) / 8) * 8;

    typedef struct packed {
        logic [3:0] src_a;
        logic [3:0] src_b;
        logic [3:0] dest_e;
        logic [3:0] dest_m;
    } dec_t;

    typedef struct packed {
        logic       en;
        logic [3:0] id_e;
        logic [3:0] id_m;
    } rf_wr_t;

    function automatic dec_t decode_regs(input logic [3:0] icode, input logic [3:0] ra,
                                         input logic [3:0] rb);
        dec_t d;
        d.src_a  = RNONE;
        d.src_b  = RNONE;
        d.dest_e = RNONE;
        d.dest_m = RNONE;
        if (icode inside {IRRMOVQ, IRMMOVQ, IOPQ, IPUSHQ})
            d.src_a = ra;
        else if (icode inside {IPOPQ, IRET})
            d.src_a = RSP;
        if (icode inside {IOPQ, IRMMOVQ, IMRMOVQ})
            d.src_b = rb;
        else if (icode inside {IPUSHQ, IPOPQ, ICALL, IRET})
            d.src_b = RSP;
        if (icode inside {IRRMOVQ, IIRMOVQ, IOPQ})
            d.dest_e = rb;
        else if (icode inside {IPUSHQ, IPOPQ, ICALL, IRET})
            d.dest_e = RSP;
        if (icode inside {IMRMOVQ, IPOPQ})
            d.dest_m = ra;
        return d;
    endfunction

endpackage

@@ sv/pdf_regfile.sv @@
// ----------------------------------------------------------------------------
// pdf_regfile: two-write, two-read register file
// Each bank takes one write per cycle; a small live-value table records
// which bank holds the newest value of a register, and valid bits make
// never-written registers read as zero.
// ----------------------------------------------------------------------------
module pdf_regfile #(
    parameter int NUM_REGS   = 15,
    parameter int DATA_WIDTH = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pdf_pkg::rf_wr_t       wr,
    input  logic [DATA_WIDTH-1:0] wr_val_e,
    input  logic [DATA_WIDTH-1:0] wr_val_m,
    input  logic                  rd_en,
    input  logic [3:0]            rd_id_a,
    input  logic [3:0]            rd_id_b,
    output logic [DATA_WIDTH-1:0] rd_data_a,
    output logic [DATA_WIDTH-1:0] rd_data_b
);
    import pdf_pkg::*;

    localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
    localparam logic [4:0] NREGS = 5'(NUM_REGS);

    logic [DATA_WIDTH-1:0] bank_e [NUM_REGS];
    logic [DATA_WIDTH-1:0] bank_m [NUM_REGS];
    logic [NUM_REGS-1:0]   valid_reg, valid_next;
    logic [NUM_REGS-1:0]   sel_m_reg, sel_m_next;

    logic [DATA_WIDTH-1:0] rd_e_a_reg, rd_m_a_reg, rd_e_b_reg, rd_m_b_reg;
    logic                  hit_a_reg, hit_a_next, hit_b_reg, hit_b_next;
    logic                  use_m_a_reg, use_m_a_next, use_m_b_reg, use_m_b_next;

    logic          we_e, we_m;
    logic [AW-1:0] wa_e, wa_m, ra_a, ra_b;
    logic          in_a, in_b;

    assign we_e = wr.en && ({1'b0, wr.id_e} < NREGS);
    assign we_m = wr.en && ({1'b0, wr.id_m} < NREGS);
    assign wa_e = wr.id_e[AW-1:0];
    assign wa_m = wr.id_m[AW-1:0];
    assign in_a = {1'b0, rd_id_a} < NREGS;
    assign in_b = {1'b0, rd_id_b} < NREGS;
    assign ra_a = rd_id_a[AW-1:0];
    assign ra_b = rd_id_b[AW-1:0];

    always_comb
    begin
        valid_next   = valid_reg;
        sel_m_next   = sel_m_reg;
        hit_a_next   = hit_a_reg;
        hit_b_next   = hit_b_reg;
        use_m_a_next = use_m_a_reg;
        use_m_b_next = use_m_b_reg;
        if (rd_en)
        begin
            hit_a_next   = in_a && valid_reg[ra_a];
            hit_b_next   = in_b && valid_reg[ra_b];
            use_m_a_next = in_a && sel_m_reg[ra_a];
            use_m_b_next = in_b && sel_m_reg[ra_b];
        end
        // The memory result is written after the ALU result, so it wins.
        if (we_e)
        begin
            valid_next[wa_e] = 1'b1;
            sel_m_next[wa_e] = 1'b0;
        end
        if (we_m)
        begin
            valid_next[wa_m] = 1'b1;
            sel_m_next[wa_m] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= '0;
            sel_m_reg   <= '0;
            hit_a_reg   <= 1'b0;
            hit_b_reg   <= 1'b0;
            use_m_a_reg <= 1'b0;
            use_m_b_reg <= 1'b0;
        end
        else
        begin
            valid_reg   <= valid_next;
            sel_m_reg   <= sel_m_next;
            hit_a_reg   <= hit_a_next;
            hit_b_reg   <= hit_b_next;
            use_m_a_reg <= use_m_a_next;
            use_m_b_reg <= use_m_b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we_e)
            bank_e[wa_e] <= wr_val_e;
        if (we_m)
            bank_m[wa_m] <= wr_val_m;
        if (rd_en && in_a)
        begin
            rd_e_a_reg <= bank_e[ra_a];
            rd_m_a_reg <= bank_m[ra_a];
        end
        if (rd_en && in_b)
        begin
            rd_e_b_reg <= bank_e[ra_b];
            rd_m_b_reg <= bank_m[ra_b];
        end
    end

    assign rd_data_a = !hit_a_reg ? '0 : (use_m_a_reg ? rd_m_a_reg : rd_e_a_reg);
    assign rd_data_b = !hit_b_reg ? '0 : (use_m_b_reg ? rd_m_b_reg : rd_e_b_reg);

endmodule

@@ sv/pipelined_decode_with_forwarding.sv @@
// ----------------------------------------------------------------------------
// pipelined_decode_with_forwarding: pipeline decode stage with forwarding
// Decodes register IDs, selects forwarded or stored operands and raises
// the bubble request for one instruction item at a time.
// ----------------------------------------------------------------------------
// The block takes one item in every clock cycle unless back-pressure stalls
// it: the register file is read into registers at the accepting edge, and
// forwarding, operand selection and the bubble test sit between those
// registers and the output register. The writeback values of an item are
// written into the register file at the edge that accepts it, so the next
// item already sees them. Output back-pressure stalls the input only when
// both the input stage and the output register are full.
module pipelined_decode_with_forwarding #(
    parameter int NUM_REGS   = 15,
    parameter int DATA_WIDTH = 64
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // icode, reg_a, reg_b, next_pc, forward_dests, execute_val_e,
    // memory_read_val, memory_stage_val_e, writeback_val_m, writeback_val_e,
    // execute_icode, branch_taken
    input  logic [pdf_pkg::S_TDATA_W-1:0] s_axis_tdata,
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // src_a, src_b, dest_e, dest_m, operand_a, operand_b, insert_bubble
    output logic [pdf_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import pdf_pkg::*;

    logic [3:0]                           in_icode, in_reg_a, in_reg_b, in_eicode;
    logic [23:0]                          in_fwd;
    logic                                 in_cnd;
    logic [DATA_WIDTH-1:0]                in_pc;
    logic [NUM_FWD-1:0][DATA_WIDTH-1:0]   in_vals;
    dec_t                                 in_dec;
    rf_wr_t                               rf_wr;
    logic                                 s_fire, out_ready;

    logic                                 s1_valid_reg, s1_valid_next;
    dec_t                                 s1_dec_reg;
    logic [3:0]                           s1_icode_reg, s1_eicode_reg;
    logic [23:0]                          s1_fwd_reg;
    logic                                 s1_cnd_reg;
    logic [DATA_WIDTH-1:0]                s1_pc_reg;
    logic [NUM_FWD-1:0][DATA_WIDTH-1:0]   s1_vals_reg;

    logic [DATA_WIDTH-1:0] rf_a, rf_b, op_a, op_b;
    logic [3:0]            e_dstm;
    logic                  bubble;

    logic                  out_valid_reg, out_valid_next;
    logic [M_TDATA_W-1:0]  out_data_reg, out_data_next;

    function automatic logic [DATA_WIDTH-1:0] pick(
        input logic [3:0]                         src,
        input logic [23:0]                        fwd,
        input logic [NUM_FWD-1:0][DATA_WIDTH-1:0] vals,
        input logic [DATA_WIDTH-1:0]              rfv
    );
        logic [DATA_WIDTH-1:0] v;
        v = rfv;
        for (int k = NUM_FWD - 1; k >= 0; k--)
        begin
            if (src == fwd[4*k +: 4])
                v = vals[k];
        end
        if (src == RNONE)
            v = '0;
        return v;
    endfunction

    assign in_icode  = s_axis_tdata[IN_ICODE_LSB +: 4];
    assign in_reg_a  = s_axis_tdata[IN_REG_A_LSB +: 4];
    assign in_reg_b  = s_axis_tdata[IN_REG_B_LSB +: 4];
    assign in_pc     = s_axis_tdata[IN_NEXT_PC_LSB +: DATA_WIDTH];
    assign in_fwd    = s_axis_tdata[IN_FWD_LSB +: 24];
    assign in_eicode = s_axis_tdata[IN_EICODE_LSB +: 4];
    assign in_cnd    = s_axis_tdata[IN_CND_LSB];

    for (genvar g = 0; g < NUM_FWD; g++)
    begin : g_vals
        assign in_vals[g] = s_axis_tdata[IN_VALS_LSB + 64*g +: DATA_WIDTH];
    end

    assign in_dec = decode_regs(in_icode, in_reg_a, in_reg_b);

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !s1_valid_reg || out_ready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    assign rf_wr.en   = s_fire;
    assign rf_wr.id_e = in_fwd[19:16];
    assign rf_wr.id_m = in_fwd[15:12];

    pdf_regfile #(
        .NUM_REGS   (NUM_REGS),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_regfile (
        .clk       (clk),
        .rst_n     (rst_n),
        .wr        (rf_wr),
        .wr_val_e  (in_vals[4]),
        .wr_val_m  (in_vals[3]),
        .rd_en     (s_fire),
        .rd_id_a   (in_dec.src_a),
        .rd_id_b   (in_dec.src_b),
        .rd_data_a (rf_a),
        .rd_data_b (rf_b)
    );

    assign e_dstm = s1_fwd_reg[23:20];
    assign op_a   = (s1_icode_reg == ICALL || s1_icode_reg == IJXX) ? s1_pc_reg
                    : pick(s1_dec_reg.src_a, s1_fwd_reg, s1_vals_reg, rf_a);
    assign op_b   = pick(s1_dec_reg.src_b, s1_fwd_reg, s1_vals_reg, rf_b);
    assign bubble = (s1_eicode_reg == IJXX && !s1_cnd_reg) ||
                    ((s1_eicode_reg == IMRMOVQ || s1_eicode_reg == IPOPQ) &&
                     (e_dstm == s1_dec_reg.src_a || e_dstm == s1_dec_reg.src_b));

    always_comb
    begin
        out_data_next = {{(M_TDATA_W - OUT_BITS){1'b0}}, bubble, 64'(op_b), 64'(op_a),
                         s1_dec_reg.dest_m, s1_dec_reg.dest_e,
                         s1_dec_reg.src_b, s1_dec_reg.src_a};
        s1_valid_next  = s_axis_tready ? s_axis_tvalid : s1_valid_reg;
        out_valid_next = out_ready ? s1_valid_reg : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_fire)
        begin
            s1_dec_reg    <= in_dec;
            s1_icode_reg  <= in_icode;
            s1_eicode_reg <= in_eicode;
            s1_fwd_reg    <= in_fwd;
            s1_cnd_reg    <= in_cnd;
            s1_pc_reg     <= in_pc;
            s1_vals_reg   <= in_vals;
        end
        if (out_ready && s1_valid_reg)
            out_data_reg <= out_data_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

@@ sv/pdf_checker.sv @@
// ----------------------------------------------------------------------------
// pdf_checker: port-level checks of the pipelined decode stage
// Watches the stream ports and the decoded fields of each result item.
// ----------------------------------------------------------------------------
module pdf_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [pdf_pkg::M_TDATA_W-1:0] m_axis_tdata
);
    import pdf_pkg::*;

    logic [3:0]  src_a, src_b, dest_m;
    logic [63:0] operand_b;

    assign src_a     = m_axis_tdata[3:0];
    assign src_b     = m_axis_tdata[7:4];
    assign dest_m    = m_axis_tdata[15:12];
    assign operand_b = m_axis_tdata[143:80];

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled while the output side could move");

    a_no_src_b_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && src_b == RNONE |-> operand_b == 64'd0)
        else $error("operand B nonzero without a source register");

    a_dest_m_src_a: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && dest_m != RNONE |-> src_a == RNONE || src_a == RSP)
        else $error("memory destination with an unexpected source A");

endmodule

bind pipelined_decode_with_forwarding pdf_checker u_pdf_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
